@@ rtl/scs_pkg.sv @@
// Shared types and constants for the searchable compacting stack.
`default_nettype none

package scs_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int DATA_W        = 32;
   localparam int MODE_W        = 3;
   localparam int LEN_W         = 9;
   localparam int STATUS_W      = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEDUP  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_TAKE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DD_OUTER,
      ST_DD_CUR,
      ST_DD_INNER,
      ST_DD_CMP,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RSEL_RD,
      RSEL_K,
      RSEL_TOP
   } rd_sel_type;

   typedef struct packed {
      logic                load_req;
      logic                push_write;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                pop_dec;
      logic                pop_take;
      logic                rd_inc;
      logic                k_load;
      logic                k_inc;
      logic                cur_load;
      logic                wr_commit;
      logic                wr_from_cur;
      logic                count_from_wr;
      logic                set_found;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic rd_done;
      logic k_done;
      logic eq_key;
      logic eq_cur;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/searchable_compacting_stack.sv @@
// Top level of the searchable compacting stack: controller joined to datapath.
`default_nettype none

// A bounded stack of signed 32-bit words with push, pop, find, delete-all-copies
// and keep-last-copy de-duplication; delete and de-duplication compact the survivors
// in order. A request is taken when start is high and busy is low, and exactly one
// response follows, presented for a single cycle with rsp_strobe high; the receiver
// cannot stall it, so it must capture the response in that cycle. Busy stays high
// until the response cycle has passed. The words sit in a single-port-read memory
// with a registered read; de-duplication compares each word against the later ones
// in turn, stopping at the first match. rsp_length reports the count modulo 512.
module searchable_compacting_stack #(
   parameter int DEPTH = scs_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [scs_pkg::MODE_W-1:0]          req_mode,
   input  wire logic signed [scs_pkg::DATA_W-1:0]   req_value,
   output logic                                     rsp_strobe,
   output logic                                     rsp_found,
   output logic signed [scs_pkg::DATA_W-1:0]        rsp_popped,
   output logic [scs_pkg::LEN_W-1:0]                rsp_length,
   output logic [scs_pkg::STATUS_W-1:0]             rsp_status
);

   scs_pkg::cmd_type  cmd;
   scs_pkg::stat_type stat;

   scs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_mode   (req_mode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   scs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_value  (req_value),
      .rsp_found  (rsp_found),
      .rsp_popped (rsp_popped),
      .rsp_length (rsp_length),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire

@@ rtl/scs_datapath.sv @@
// Datapath of the stack: entry memory, fill count, scan indices and result registers.
`default_nettype none

module scs_datapath #(
   parameter int DEPTH = scs_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire scs_pkg::cmd_type              cmd,
   output scs_pkg::stat_type                  stat,
   input  wire logic [scs_pkg::DATA_W-1:0]    req_value,
   output logic                               rsp_found,
   output logic signed [scs_pkg::DATA_W-1:0]  rsp_popped,
   output logic [scs_pkg::LEN_W-1:0]          rsp_length,
   output logic [scs_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int LenW  = scs_pkg::LEN_W;
   localparam int DataW = scs_pkg::DATA_W;

   logic [DataW-1:0] mem [DEPTH];

   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    wr_ff, wr_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [DataW-1:0] key_ff;
   logic [DataW-1:0] cur_ff;
   logic [DataW-1:0] rdata_ff;
   logic             found_ff;
   logic [DataW-1:0] popped_ff;
   logic [scs_pkg::STATUS_W-1:0] status_ff;

   logic [CW-1:0]    top_idx;
   logic [CW-1:0]    rd_addr;
   logic [CW-1:0]    wr_addr;
   logic [DataW-1:0] wr_data;
   logic             wr_en;

   assign top_idx = count_ff - CW'(1);

   always_comb begin
      case (cmd.rd_sel)
         scs_pkg::RSEL_RD:  rd_addr = rd_ff;
         scs_pkg::RSEL_K:   rd_addr = k_ff;
         scs_pkg::RSEL_TOP: rd_addr = top_idx;
         default:           rd_addr = rd_ff;
      endcase
   end

   // A push writes the incoming word on top; compaction writes a survivor at the write index.
   always_comb begin
      wr_en   = cmd.push_write || cmd.wr_commit;
      wr_addr = cmd.push_write ? count_ff : wr_ff;
      if (cmd.push_write) begin
         wr_data = req_value;
      end else if (cmd.wr_from_cur) begin
         wr_data = cur_ff;
      end else begin
         wr_data = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push_write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_dec) begin
         count_in = top_idx;
      end else if (cmd.count_from_wr) begin
         count_in = wr_ff;
      end

      rd_in = rd_ff;
      if (cmd.load_req) begin
         rd_in = '0;
      end else if (cmd.rd_inc) begin
         rd_in = rd_ff + CW'(1);
      end

      wr_in = wr_ff;
      if (cmd.load_req) begin
         wr_in = '0;
      end else if (cmd.wr_commit) begin
         wr_in = wr_ff + CW'(1);
      end

      k_in = k_ff;
      if (cmd.k_load) begin
         k_in = rd_ff + CW'(1);
      end else if (cmd.k_inc) begin
         k_in = k_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
         wr_ff    <= '0;
         k_ff     <= '0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff    <= req_value;
         found_ff  <= 1'b0;
         popped_ff <= '0;
         status_ff <= cmd.set_status ? cmd.status_code : scs_pkg::STATUS_OK;
      end else begin
         if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
         if (cmd.pop_take) begin
            popped_ff <= rdata_ff;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
      end
      if (cmd.cur_load) begin
         cur_ff <= rdata_ff;
      end
   end

   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CW'(DEPTH));
   assign stat.rd_done = (rd_ff == count_ff);
   assign stat.k_done  = (k_ff == count_ff);
   assign stat.eq_key  = (rdata_ff == key_ff);
   assign stat.eq_cur  = (rdata_ff == cur_ff);

   assign rsp_found  = found_ff;
   assign rsp_popped = popped_ff;
   assign rsp_length = LenW'(count_ff);
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

@@ rtl/scs_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module scs_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [scs_pkg::MODE_W-1:0]   req_mode,
   input  wire scs_pkg::stat_type            stat,
   output scs_pkg::cmd_type                  cmd,
   output logic                              busy,
   output logic                              rsp_strobe
);

   scs_pkg::state_type state_ff, state_in;
   logic [scs_pkg::MODE_W-1:0] mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scs_pkg::ST_IDLE;
         mode_ff  <= scs_pkg::MODE_PUSH;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      cmd        = '0;
      cmd.rd_sel = scs_pkg::RSEL_RD;
      busy       = (state_ff != scs_pkg::ST_IDLE);
      rsp_strobe = 1'b0;

      case (state_ff)
         scs_pkg::ST_IDLE: begin
            if (start) begin
               mode_in      = req_mode;
               cmd.load_req = 1'b1;
               case (req_mode)
                  scs_pkg::MODE_PUSH: begin
                     if (stat.full) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = scs_pkg::STATUS_FULL;
                     end else begin
                        cmd.push_write = 1'b1;
                     end
                     state_in = scs_pkg::ST_RESP;
                  end
                  scs_pkg::MODE_POP: begin
                     if (stat.empty) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = scs_pkg::STATUS_EMPTY;
                        state_in        = scs_pkg::ST_RESP;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = scs_pkg::RSEL_TOP;
                        cmd.pop_dec = 1'b1;
                        state_in    = scs_pkg::ST_POP_TAKE;
                     end
                  end
                  scs_pkg::MODE_FIND, scs_pkg::MODE_DELETE: begin
                     state_in = scs_pkg::ST_SCAN_RD;
                  end
                  scs_pkg::MODE_DEDUP: begin
                     state_in = scs_pkg::ST_DD_OUTER;
                  end
                  default: begin
                     state_in = scs_pkg::ST_RESP;
                  end
               endcase
            end
         end

         scs_pkg::ST_POP_TAKE: begin
            cmd.pop_take = 1'b1;
            state_in     = scs_pkg::ST_RESP;
         end

         scs_pkg::ST_SCAN_RD: begin
            if (stat.rd_done) begin
               cmd.count_from_wr = (mode_ff == scs_pkg::MODE_DELETE);
               state_in          = scs_pkg::ST_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = scs_pkg::ST_SCAN_CHK;
            end
         end

         scs_pkg::ST_SCAN_CHK: begin
            cmd.rd_inc = 1'b1;
            state_in   = scs_pkg::ST_SCAN_RD;
            if (mode_ff == scs_pkg::MODE_FIND) begin
               if (stat.eq_key) begin
                  cmd.set_found = 1'b1;
                  state_in      = scs_pkg::ST_RESP;
               end
            end else if (!stat.eq_key) begin
               cmd.wr_commit = 1'b1;
            end
         end

         scs_pkg::ST_DD_OUTER: begin
            if (stat.rd_done) begin
               cmd.count_from_wr = 1'b1;
               state_in          = scs_pkg::ST_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = scs_pkg::ST_DD_CUR;
            end
         end

         scs_pkg::ST_DD_CUR: begin
            cmd.cur_load = 1'b1;
            cmd.k_load   = 1'b1;
            state_in     = scs_pkg::ST_DD_INNER;
         end

         // A word survives only if no later entry holds the same value.
         scs_pkg::ST_DD_INNER: begin
            if (stat.k_done) begin
               cmd.wr_commit   = 1'b1;
               cmd.wr_from_cur = 1'b1;
               cmd.rd_inc      = 1'b1;
               state_in        = scs_pkg::ST_DD_OUTER;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = scs_pkg::RSEL_K;
               state_in   = scs_pkg::ST_DD_CMP;
            end
         end

         scs_pkg::ST_DD_CMP: begin
            if (stat.eq_cur) begin
               cmd.rd_inc = 1'b1;
               state_in   = scs_pkg::ST_DD_OUTER;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = scs_pkg::ST_DD_INNER;
            end
         end

         scs_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = scs_pkg::ST_IDLE;
         end

         default: begin
            state_in = scs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the searchable compacting stack.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = scs_pkg::DEPTH_DEFAULT;
   localparam int DATA_W      = scs_pkg::DATA_W;
   localparam int MODE_W      = scs_pkg::MODE_W;
   localparam int LEN_W       = scs_pkg::LEN_W;
   localparam int STATUS_W    = scs_pkg::STATUS_W;
   localparam int IDLE_LIMIT  = 350000;
   localparam int POOL_SIZE   = 6;
   localparam logic [MODE_W-1:0] MODE_RESERVED_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RESERVED_LAST  = 3'd7;

   typedef struct packed {
      logic                       found;
      logic signed [DATA_W-1:0]   popped;
      logic [LEN_W-1:0]           length;
      logic [STATUS_W-1:0]        status;
   } stack_reply_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic [MODE_W-1:0]          req_mode;
   logic signed [DATA_W-1:0]   req_value;
   wire                        busy;
   wire                        rsp_strobe;
   wire                        rsp_found;
   wire signed [DATA_W-1:0]    rsp_popped;
   wire [LEN_W-1:0]            rsp_length;
   wire [STATUS_W-1:0]         rsp_status;

   // Shadow copy of the stack, updated when each request is taken.
   logic signed [DATA_W-1:0]   shadow_words [STACK_DEPTH];
   int                         shadow_fill;
   stack_reply_type            replies_due [$];
   logic signed [DATA_W-1:0]   value_pool [POOL_SIZE];
   bit                         gaps_enabled;
   int                         error_count;
   int                         idle_cycles;

   searchable_compacting_stack #(
      .DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found),
      .rsp_popped(rsp_popped),
      .rsp_length(rsp_length),
      .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic perform_stack_op(input logic [MODE_W-1:0] mode,
                                   input logic signed [DATA_W-1:0] value,
                                   output stack_reply_type reply);
      int rd;
      int wr;
      int k;
      bit later;
      reply = '0;
      case (mode)
         scs_pkg::MODE_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               reply.status = scs_pkg::STATUS_FULL;
            end else begin
               shadow_words[shadow_fill] = value;
               shadow_fill++;
            end
         end
         scs_pkg::MODE_POP: begin
            if (shadow_fill == 0) begin
               reply.status = scs_pkg::STATUS_EMPTY;
            end else begin
               shadow_fill--;
               reply.popped = shadow_words[shadow_fill];
            end
         end
         scs_pkg::MODE_FIND: begin
            for (rd = 0; rd < shadow_fill; rd++)
               if (shadow_words[rd] == value) reply.found = 1'b1;
         end
         scs_pkg::MODE_DELETE: begin
            wr = 0;
            for (rd = 0; rd < shadow_fill; rd++) begin
               if (shadow_words[rd] != value) begin
                  shadow_words[wr] = shadow_words[rd];
                  wr++;
               end
            end
            shadow_fill = wr;
         end
         scs_pkg::MODE_DEDUP: begin
            // A word survives only if no copy of it sits higher up the stack.
            wr = 0;
            for (rd = 0; rd < shadow_fill; rd++) begin
               later = 1'b0;
               for (k = rd + 1; k < shadow_fill && !later; k++)
                  if (shadow_words[k] == shadow_words[rd]) later = 1'b1;
               if (!later) begin
                  shadow_words[wr] = shadow_words[rd];
                  wr++;
               end
            end
            shadow_fill = wr;
         end
         default: begin
         end
      endcase
      reply.length = LEN_W'(shadow_fill);
   endtask

   // Presents one request and returns at the edge that takes it, leaving start high.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic signed [DATA_W-1:0] value);
      stack_reply_type reply;
      int gap;
      if (gaps_enabled && $urandom_range(0, 99) < 18) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (busy);
      perform_stack_op(mode, value, reply);
      replies_due.push_back(reply);
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_stack();
      logic [MODE_W-1:0] m;
      send_request(scs_pkg::MODE_POP, 32'h1234_5678);
      send_request(scs_pkg::MODE_FIND, 32'h0);
      send_request(scs_pkg::MODE_DELETE, 32'h0);
      send_request(scs_pkg::MODE_DEDUP, 32'hFFFF_FFFF);
      for (m = MODE_RESERVED_FIRST; m != MODE_RESERVED_LAST; m++)
         send_request(m, $urandom);
      send_request(MODE_RESERVED_LAST, $urandom);
   endtask

   task automatic test_extreme_values();
      send_request(scs_pkg::MODE_PUSH, 32'h8000_0000);
      send_request(scs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
      send_request(scs_pkg::MODE_PUSH, 32'hFFFF_FFFF);
      send_request(scs_pkg::MODE_PUSH, 32'h0);
      send_request(scs_pkg::MODE_PUSH, 32'h5555_5555);
      send_request(scs_pkg::MODE_PUSH, 32'hAAAA_AAAA);
      send_request(scs_pkg::MODE_FIND, 32'h8000_0000);
      send_request(scs_pkg::MODE_FIND, 32'h7FFF_FFFE);
      send_request(scs_pkg::MODE_POP, 32'h0);
      send_request(scs_pkg::MODE_POP, 32'hFFFF_FFFF);
   endtask

   task automatic test_delete_and_dedup();
      send_request(scs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
      send_request(scs_pkg::MODE_PUSH, 32'h0);
      send_request(scs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
      send_request(scs_pkg::MODE_DELETE, 32'h7FFF_FFFF);
      send_request(scs_pkg::MODE_DEDUP, 32'h0);
      send_request(scs_pkg::MODE_FIND, 32'h0);
      send_request(scs_pkg::MODE_DELETE, 32'h1357_9BDF);
   endtask

   task automatic test_full_stack();
      logic signed [DATA_W-1:0] pattern [4];
      int i;
      while (shadow_fill > 0) send_request(scs_pkg::MODE_POP, $urandom);
      // The top byte carries the index, so every word is distinct.
      for (i = 0; i < STACK_DEPTH; i++)
         send_request(scs_pkg::MODE_PUSH, {8'(i), 24'($urandom)});
      send_request(scs_pkg::MODE_PUSH, $urandom);
      send_request(scs_pkg::MODE_FIND, shadow_words[0]);
      send_request(scs_pkg::MODE_FIND, shadow_words[STACK_DEPTH-1]);
      send_request(scs_pkg::MODE_DEDUP, $urandom);
      send_request(scs_pkg::MODE_DELETE, shadow_words[100]);
      send_request(scs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
      send_request(scs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
      send_request(scs_pkg::MODE_POP, $urandom);
      wait_for_replies();

      pattern[0] = 32'h8000_0000;
      pattern[1] = 32'h7FFF_FFFF;
      pattern[2] = 32'h0;
      pattern[3] = $urandom;
      while (shadow_fill < STACK_DEPTH)
         send_request(scs_pkg::MODE_PUSH, pattern[$urandom_range(0, 3)]);
      send_request(scs_pkg::MODE_DEDUP, $urandom);
      send_request(scs_pkg::MODE_DELETE, pattern[0]);
      while (shadow_fill > 0) send_request(scs_pkg::MODE_POP, $urandom);
      send_request(scs_pkg::MODE_POP, $urandom);
   endtask

   task automatic test_random_traffic(input int total);
      int done;
      int phase_no;
      int phase_len;
      int target;
      int pick;
      int i;
      logic [MODE_W-1:0] mode;
      logic signed [DATA_W-1:0] value;
      done     = 0;
      phase_no = 0;
      while (done < total) begin
         phase_len = $urandom_range(100, 200);
         target = (phase_no == 3) ? $urandom_range(100, 160) : $urandom_range(2, 40);
         // One phase runs back to back with no idle cycles from the sender.
         gaps_enabled = (phase_no != 1);
         for (i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(0, 7))
               0:       value_pool[i] = 32'h8000_0000;
               1:       value_pool[i] = 32'h7FFF_FFFF;
               2:       value_pool[i] = 32'h0;
               3:       value_pool[i] = 32'hFFFF_FFFF;
               default: value_pool[i] = $urandom;
            endcase
         end
         for (i = 0; i < phase_len && done < total; i++) begin
            pick  = $urandom_range(0, 99);
            value = ($urandom_range(0, 7) == 0) ? $urandom
                                                : value_pool[$urandom_range(0, POOL_SIZE-1)];
            if (pick < ((shadow_fill < target) ? 50 : 25)) begin
               mode = scs_pkg::MODE_PUSH;
            end else if (pick < 70) begin
               mode = scs_pkg::MODE_POP;
            end else if (pick < 84) begin
               mode = scs_pkg::MODE_FIND;
            end else if (pick < 92) begin
               mode = scs_pkg::MODE_DELETE;
            end else if (pick < 97) begin
               // De-duplication of a deep stack is slow, so it is kept rare there.
               mode = (shadow_fill <= 64 || $urandom_range(0, 19) == 0) ? scs_pkg::MODE_DEDUP
                                                                         : scs_pkg::MODE_FIND;
            end else begin
               mode = MODE_W'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST));
            end
            send_request(mode, value);
            done++;
         end
         if (phase_no == 2) wait_for_replies();
         phase_no++;
      end
      gaps_enabled = 1'b1;
   endtask

   always @(posedge clock) begin
      stack_reply_type due;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (replies_due.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               error_count++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_found !== due.found) begin
                  $display("%0t: found mismatch, expected %0d, actual %0d",
                           $time, due.found, rsp_found);
                  error_count++;
               end
               if (rsp_popped !== due.popped) begin
                  $display("%0t: popped mismatch, expected %h, actual %h",
                           $time, due.popped, rsp_popped);
                  error_count++;
               end
               if (rsp_length !== due.length) begin
                  $display("%0t: length mismatch, expected %0d, actual %0d",
                           $time, due.length, rsp_length);
                  error_count++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, due.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (rsp_strobe === 1'b1 || (start && busy === 1'b0)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or response for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      error_count  = 0;
      gaps_enabled = 1'b1;
      shadow_fill  = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_mode  <= scs_pkg::MODE_PUSH;
      req_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_extreme_values();
      test_delete_and_dedup();
      wait_for_replies();
      test_full_stack();
      wait_for_replies();
      test_random_traffic(1250);
      wait_for_replies();
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ searchable_compacting_stack.f @@
rtl/scs_pkg.sv
rtl/scs_datapath.sv
rtl/scs_ctrl.sv
rtl/searchable_compacting_stack.sv
bench/testbench.sv
